// ----- src/convex_polygon_span_rasterizer_top_macros.svh -----
// Assertion helpers shared by the RTL files.
// Each helper expects clk and arst_n in the scope where it is used.
`ifndef CONVEX_POLYGON_SPAN_RASTERIZER_TOP_MACROS_SVH
`define CONVEX_POLYGON_SPAN_RASTERIZER_TOP_MACROS_SVH
// The property is checked at every clock edge outside reset.
`define CPSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// The condition at one edge requires the property at the next edge.
`define CPSR_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);
`endif

// ----- src/cpsr_pkg.sv -----
`timescale 1ns / 1ps
package cpsr_pkg;
	localparam int CW = 16;
	localparam int AW = CW + 4;
	localparam int MHS_W = 10;
	localparam int CF_W = 5;
	localparam int CFG_DW = 10;
	localparam int CFG_IW = 1;

	localparam logic [CFG_IW-1:0] CFG_MAP_HALF_SIZE = 1'd0;
	localparam logic [CFG_IW-1:0] CFG_CELL_FACTOR = 1'd1;

	localparam logic [MHS_W-1:0] MHS_RESET = 10'd70;
	localparam logic [CF_W-1:0] CF_RESET = 5'd5;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_VERTS = 2'd1;
	localparam logic [1:0] ERR_ROWS = 2'd2;

	typedef struct packed {
		logic signed [CW-1:0] vertex_x;
		logic signed [CW-1:0] vertex_y;
		logic last_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [CW-1:0] row_y;
		logic signed [CW-1:0] span_start;
		logic signed [CW-1:0] span_end;
		logic visible;
		logic [1:0] error;
		logic last_row;
	} span_t;

	// Unclipped row as the sequencer produces it.
	typedef struct packed {
		logic signed [CW-1:0] row_y;
		logic signed [CW-1:0] x_min;
		logic signed [CW-1:0] x_max;
		logic covered;
		logic [1:0] error;
		logic last_row;
	} raw_row_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ERR,
		ST_YRD,
		ST_YLO,
		ST_YHI,
		ST_ROWS,
		ST_ERD0,
		ST_ERD1,
		ST_ELD1,
		ST_SDY,
		ST_SADX,
		ST_SADY,
		ST_SMAJ,
		ST_SD,
		ST_SINC,
		ST_WRD,
		ST_WUPD,
		ST_EMRD,
		ST_EMIT
	} seq_state_t;
endpackage

// ----- src/cpsr_alu.sv -----
`timescale 1ns / 1ps
module cpsr_alu import cpsr_pkg::*; (
	input  logic signed [AW-1:0] a,
	input  logic signed [AW-1:0] b,
	input  alu_op_t              op,
	output logic signed [AW-1:0] res,
	output logic                 neg,
	output logic                 zero
);
	always_comb begin
		unique case (op)
			ALU_ADD: res = a + b;
			ALU_SUB: res = a - b;
		endcase
	end

	assign neg = res[AW-1];
	assign zero = (res == '0);
endmodule

// ----- src/cpsr_core.sv -----
`timescale 1ns / 1ps
`include "convex_polygon_span_rasterizer_top_macros.svh"
module cpsr_core import cpsr_pkg::*; #(
	parameter int MAXV = 16,
	parameter int MAXR = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     vtx_valid,
	output logic     vtx_ready,
	input  vertex_t  vtx,
	output logic     raw_valid,
	input  logic     raw_ready,
	output raw_row_t raw
);
	localparam int VAW = $clog2(MAXV);
	localparam int VCW = $clog2(MAXV + 1);
	localparam int RIW = $clog2(MAXR);
	localparam logic [CW:0] REM_ONE = {{CW{1'b0}}, 1'b1};

	function automatic logic signed [AW-1:0] ext(input logic signed [CW-1:0] v);
		ext = {{(AW-CW){v[CW-1]}}, v};
	endfunction

	seq_state_t state_q, state_d;

	logic [VCW-1:0] cnt_q, n_q, n_m1;
	logic ovf_q;
	logic [VAW-1:0] ei_q, ej;
	logic [RIW-1:0] ri_q, r_q, span_q;
	logic [1:0] err_q;
	logic [MAXR-1:0] touched_q;

	logic signed [CW-1:0] lo_q, hi_q, xc_q, yc_q;
	logic signed [AW-1:0] dx_q, dy_q, lng_q, sht_q, d_q, inch_q;
	logic sx_q, sy_q, xmaj_q;
	logic [CW:0] rem_q;

	logic [2*CW-1:0] vmem [MAXV];
	logic [2*CW-1:0] v_rd_q;
	logic v_re;
	logic [VAW-1:0] v_ra;
	logic signed [CW-1:0] rd_x, rd_y;

	logic [2*CW-1:0] rmem [MAXR];
	logic [2*CW-1:0] r_rd_q, r_wd;
	logic r_re, r_we;
	logic [RIW-1:0] r_ra;
	logic signed [CW-1:0] mem_min, mem_max, new_min, new_max;

	logic signed [AW-1:0] alu_a, alu_b, alu_res;
	alu_op_t alu_op;
	logic alu_neg, alu_zero;

	logic vtx_fire, store_ok, edge_last, rows_bad, walk_done, diag, edge_adv, last_row;
	logic [CW-1:0] row_off;
	logic signed [CW-1:0] x_step, y_step;

	cpsr_alu u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.op   (alu_op),
		.res  (alu_res),
		.neg  (alu_neg),
		.zero (alu_zero)
	);

	assign rd_x = v_rd_q[2*CW-1:CW];
	assign rd_y = v_rd_q[CW-1:0];
	assign mem_min = r_rd_q[2*CW-1:CW];
	assign mem_max = r_rd_q[CW-1:0];

	assign vtx_fire = vtx_valid && vtx_ready;
	assign store_ok = (cnt_q < VCW'(MAXV));
	assign n_m1 = n_q - VCW'(1);
	assign edge_last = (VCW'(ei_q) == n_m1);
	assign ej = edge_last ? '0 : ei_q + VAW'(1);
	assign rows_bad = (alu_res > $signed(AW'(MAXR - 1)));
	assign walk_done = (rem_q == REM_ONE);
	assign diag = !d_q[AW-1];
	assign row_off = yc_q - lo_q;
	assign last_row = (ri_q == span_q);
	assign edge_adv = ((state_q == ST_SDY) && alu_zero) || ((state_q == ST_WUPD) && walk_done);

	// A diagonal step moves both axes; otherwise only the major axis moves.
	assign x_step = (diag || xmaj_q) ? (sx_q ? '1 : CW'(1)) : '0;
	assign y_step = (diag || !xmaj_q) ? (sy_q ? '1 : CW'(1)) : '0;

	// A row not yet touched in this polygon takes the point as both ends.
	assign new_min = (!touched_q[r_q] || (xc_q < mem_min)) ? xc_q : mem_min;
	assign new_max = (!touched_q[r_q] || (xc_q > mem_max)) ? xc_q : mem_max;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (vtx_fire && vtx.last_vertex) begin
					state_d = (ovf_q || !store_ok) ? ST_ERR : ST_YRD;
				end
			end
			ST_ERR: begin
				if (raw_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_YRD: state_d = ST_YLO;
			ST_YLO: state_d = ST_YHI;
			ST_YHI: state_d = edge_last ? ST_ROWS : ST_YRD;
			ST_ROWS: state_d = rows_bad ? ST_ERR : ST_ERD0;
			ST_ERD0: state_d = ST_ERD1;
			ST_ERD1: state_d = ST_ELD1;
			ST_ELD1: state_d = ST_SDY;
			ST_SDY: begin
				if (alu_zero) begin
					state_d = edge_last ? ST_EMRD : ST_ERD0;
				end else begin
					state_d = ST_SADX;
				end
			end
			ST_SADX: state_d = ST_SADY;
			ST_SADY: state_d = ST_SMAJ;
			ST_SMAJ: state_d = ST_SD;
			ST_SD: state_d = ST_SINC;
			ST_SINC: state_d = ST_WRD;
			ST_WRD: state_d = ST_WUPD;
			ST_WUPD: begin
				if (walk_done) begin
					state_d = edge_last ? ST_EMRD : ST_ERD0;
				end else begin
					state_d = ST_WRD;
				end
			end
			ST_EMRD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (raw_ready) begin
					state_d = last_row ? ST_IDLE : ST_EMRD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		vtx_ready = 1'b0;
		raw_valid = 1'b0;
		raw = '0;
		v_re = 1'b0;
		v_ra = ei_q;
		r_re = 1'b0;
		r_ra = ri_q;
		r_we = 1'b0;
		r_wd = {new_min, new_max};
		alu_a = '0;
		alu_b = '0;
		alu_op = ALU_SUB;
		unique case (state_q)
			ST_IDLE: vtx_ready = 1'b1;
			ST_ERR: begin
				raw_valid = 1'b1;
				raw.error = err_q;
				raw.last_row = 1'b1;
			end
			ST_YRD: v_re = 1'b1;
			ST_YLO: begin
				alu_a = ext(rd_y);
				alu_b = ext(lo_q);
			end
			ST_YHI: begin
				alu_a = ext(hi_q);
				alu_b = ext(rd_y);
			end
			ST_ROWS: begin
				alu_a = ext(hi_q);
				alu_b = ext(lo_q);
			end
			ST_ERD0: v_re = 1'b1;
			ST_ERD1: begin
				v_re = 1'b1;
				v_ra = ej;
			end
			ST_ELD1: begin
				alu_a = ext(rd_x);
				alu_b = ext(xc_q);
			end
			ST_SDY: begin
				alu_a = ext(rd_y);
				alu_b = ext(yc_q);
			end
			ST_SADX: alu_b = dx_q;
			ST_SADY: alu_b = dy_q;
			ST_SMAJ: begin
				alu_a = dx_q;
				alu_b = dy_q;
			end
			ST_SD: begin
				alu_a = sht_q <<< 1;
				alu_b = lng_q;
			end
			ST_SINC: begin
				alu_a = sht_q <<< 1;
				alu_b = lng_q <<< 1;
			end
			ST_WRD: begin
				r_re = 1'b1;
				r_ra = row_off[RIW-1:0];
			end
			ST_WUPD: begin
				r_we = 1'b1;
				alu_op = ALU_ADD;
				alu_a = d_q;
				alu_b = diag ? inch_q : (sht_q <<< 1);
			end
			ST_EMRD: r_re = 1'b1;
			ST_EMIT: begin
				raw_valid = 1'b1;
				alu_op = ALU_ADD;
				alu_a = ext(lo_q);
				alu_b = {{(AW-RIW){1'b0}}, ri_q};
				raw.row_y = alu_res[CW-1:0];
				raw.x_min = mem_min;
				raw.x_max = mem_max;
				raw.covered = touched_q[ri_q];
				raw.error = ERR_NONE;
				raw.last_row = last_row;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			ovf_q <= 1'b0;
			n_q <= '0;
			ei_q <= '0;
			ri_q <= '0;
			err_q <= ERR_NONE;
			touched_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (vtx_fire) begin
						if (vtx.last_vertex) begin
							cnt_q <= '0;
							ovf_q <= 1'b0;
							n_q <= store_ok ? cnt_q + VCW'(1) : cnt_q;
							ei_q <= '0;
							err_q <= ERR_VERTS;
						end else if (store_ok) begin
							cnt_q <= cnt_q + VCW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_YHI: ei_q <= edge_last ? '0 : ei_q + VAW'(1);
				ST_ROWS: begin
					if (rows_bad) begin
						err_q <= ERR_ROWS;
					end else begin
						touched_q <= '0;
					end
				end
				ST_WUPD: touched_q[r_q] <= 1'b1;
				ST_EMIT: begin
					if (raw_ready && !last_row) begin
						ri_q <= ri_q + RIW'(1);
					end
				end
				default: ;
			endcase
			if (edge_adv) begin
				if (edge_last) begin
					ri_q <= '0;
				end else begin
					ei_q <= ei_q + VAW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_YLO: begin
				if (ei_q == '0 || alu_neg) begin
					lo_q <= rd_y;
				end
			end
			ST_YHI: begin
				if (ei_q == '0 || alu_neg) begin
					hi_q <= rd_y;
				end
			end
			ST_ROWS: span_q <= alu_res[RIW-1:0];
			ST_ERD1: begin
				xc_q <= rd_x;
				yc_q <= rd_y;
			end
			ST_ELD1: dx_q <= alu_res;
			ST_SDY: dy_q <= alu_res;
			ST_SADX: begin
				sx_q <= dx_q[AW-1];
				if (dx_q[AW-1]) begin
					dx_q <= alu_res;
				end
			end
			ST_SADY: begin
				sy_q <= dy_q[AW-1];
				if (dy_q[AW-1]) begin
					dy_q <= alu_res;
				end
			end
			ST_SMAJ: begin
				xmaj_q <= !alu_neg;
				lng_q <= alu_neg ? dy_q : dx_q;
				sht_q <= alu_neg ? dx_q : dy_q;
			end
			ST_SD: d_q <= alu_res;
			ST_SINC: begin
				inch_q <= alu_res;
				rem_q <= lng_q[CW:0] + REM_ONE;
			end
			ST_WRD: r_q <= row_off[RIW-1:0];
			ST_WUPD: begin
				if (!walk_done) begin
					d_q <= alu_res;
					xc_q <= xc_q + x_step;
					yc_q <= yc_q + y_step;
					rem_q <= rem_q - REM_ONE;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (vtx_fire && store_ok) begin
			vmem[cnt_q[VAW-1:0]] <= {vtx.vertex_x, vtx.vertex_y};
		end
		if (v_re) begin
			v_rd_q <= vmem[v_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (r_we) begin
			rmem[r_q] <= r_wd;
		end
		if (r_re) begin
			r_rd_q <= rmem[r_ra];
		end
	end

	`CPSR_ASSERT(a_cnt_range, cnt_q <= VCW'(MAXV), "vertex count beyond store depth")
	`CPSR_ASSERT(a_err_last, (raw_valid && raw.error != ERR_NONE) |-> raw.last_row, "error row not last")
	`CPSR_ASSERT(a_walk_rem, (state_q == ST_WUPD) |-> (rem_q != '0), "edge walk ran past its end")
	`CPSR_ASSERT_NEXT(a_last_clears, vtx_fire && vtx.last_vertex, (cnt_q == '0) && !ovf_q, "vertex count not cleared")
	`CPSR_ASSERT_NEXT(a_busy_hold, state_q != ST_IDLE, $stable(cnt_q), "vertex count moved while busy")
endmodule

// ----- src/convex_polygon_span_rasterizer_top.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake                      Beat
// vertex    in         vertex_valid / vertex_ready    vertex_t: x, y, last_vertex
// span      out        span_valid / span_ready        span_t: one row, or one error
// cfg       in         cfg_we, cfg_index, cfg_data    map_half_size (0), cell_factor (1)
//
// A vertex without last_vertex is taken while idle; the final vertex starts the sequencer.
// Sequencer: a pass over the vertices for the y range, a check of the row count, then per
// edge a read of both ends, a setup if it is not horizontal and a walk over its Bresenham
// points (max(|dx|,|dy|)+1 of them), then a beat per row emitted, or one error beat. Reset
// clears the sequencer, the vertex count and the registers (70, 5).
// The last span beat of a polygon can wait in the output register while the next one loads.
`include "convex_polygon_span_rasterizer_top_macros.svh"
module convex_polygon_span_rasterizer_top import cpsr_pkg::*; #(
	parameter int MAX_VERTICES = 16,
	parameter int MAX_ROWS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	input  logic              vertex_valid,
	output logic              vertex_ready,
	input  vertex_t           vertex,
	output logic              span_valid,
	input  logic              span_ready,
	output span_t             span
);
	logic [MHS_W-1:0] mhs_q;
	logic [CF_W-1:0] cf_q;
	logic [CW-1:0] w_sum;
	logic signed [CW:0] w_q, nw, ry_e, s_e, e_e, s_c, e_c;

	logic raw_valid, raw_ready, in_win, vis;
	raw_row_t raw;
	span_t span_d, span_q;
	logic span_valid_q;

	cpsr_core #(
		.MAXV (MAX_VERTICES),
		.MAXR (MAX_ROWS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vertex_valid),
		.vtx_ready (vertex_ready),
		.vtx       (vertex),
		.raw_valid (raw_valid),
		.raw_ready (raw_ready),
		.raw       (raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mhs_q <= MHS_RESET;
			cf_q <= CF_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAP_HALF_SIZE: mhs_q <= cfg_data[MHS_W-1:0];
				CFG_CELL_FACTOR: cf_q <= cfg_data[CF_W-1:0];
			endcase
		end
	end

	// Window half width; a zero cell factor gives -1, which hides every row.
	assign w_sum = CW'(cf_q) * CW'(mhs_q) + CW'(cf_q);

	always_ff @(posedge clk) begin
		w_q <= $signed({1'b0, w_sum}) - $signed((CW+1)'(1));
	end

	assign nw = -w_q;
	assign ry_e = {raw.row_y[CW-1], raw.row_y};
	assign s_e = {raw.x_min[CW-1], raw.x_min};
	assign e_e = {raw.x_max[CW-1], raw.x_max};
	assign in_win = (ry_e >= nw) && (ry_e <= w_q);
	assign s_c = (s_e < nw) ? nw : s_e;
	assign e_c = (e_e > w_q) ? w_q : e_e;
	assign vis = raw.covered && (raw.error == ERR_NONE) && in_win && (s_c <= e_c);

	always_comb begin
		span_d.row_y = raw.row_y;
		span_d.span_start = vis ? s_c[CW-1:0] : '0;
		span_d.span_end = vis ? e_c[CW-1:0] : '0;
		span_d.visible = vis;
		span_d.error = raw.error;
		span_d.last_row = raw.last_row;
	end

	assign raw_ready = !span_valid_q || span_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (raw_ready) begin
			span_valid_q <= raw_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw_valid && raw_ready) begin
			span_q <= span_d;
		end
	end

	assign span_valid = span_valid_q;
	assign span = span_q;

	`CPSR_ASSERT(a_vis_order, (span_valid_q && span_q.visible) |-> (span_q.span_start <= span_q.span_end), "visible span reversed")
	`CPSR_ASSERT(a_hidden_zero, (span_valid_q && !span_q.visible) |-> (span_q.span_start == '0 && span_q.span_end == '0), "hidden span not zero")
	`CPSR_ASSERT(a_err_final, (span_valid_q && span_q.error != ERR_NONE) |-> (span_q.last_row && !span_q.visible), "error beat malformed")
endmodule
